// File: rtl/itrt_pkg.sv
// shared types and constants for the integer to radix text converter
package itrt_pkg;

    // data widths
    localparam int WORD_W    = 64;
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = WORD_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int DIGIT_W   = 6;
    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 7;

    // radix limits and fallback
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;

    // character mapping
    localparam logic [DIGIT_W-1:0] DIGIT_TEN       = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO       = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA_BASE = 7'd87;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_read;
        logic emit_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic step_last;
        logic quot_zero;
        logic digits_full;
        logic emit_last;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/itrt_ram.sv
// generic single write port, single read port ram with registered read
module itrt_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/itrt_ctrl.sv
// controller state machine: sequences division steps and character emission
module itrt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  itrt_pkg::stat_t stat,
    output itrt_pkg::cmd_t  cmd
);

    itrt_pkg::state_t state_reg;
    itrt_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itrt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itrt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = itrt_pkg::ST_DIV;
                end
            end
            itrt_pkg::ST_DIV:
            begin
                if (stat.step_last && (stat.quot_zero || stat.digits_full))
                begin
                    state_next = itrt_pkg::ST_EMIT_RD;
                end
            end
            itrt_pkg::ST_EMIT_RD:
            begin
                if (stat.out_free)
                begin
                    state_next = itrt_pkg::ST_EMIT_LD;
                end
            end
            itrt_pkg::ST_EMIT_LD:
            begin
                if (stat.emit_last)
                begin
                    state_next = itrt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = itrt_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = itrt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            itrt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            itrt_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            itrt_pkg::ST_EMIT_RD:
            begin
                cmd.emit_read = stat.out_free;
            end
            itrt_pkg::ST_EMIT_LD:
            begin
                cmd.emit_load = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/itrt_dpath.sv
// datapath: radix register, digit-serial divider, digit store and output register
module itrt_dpath #(
    parameter int MAX_DIGITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  itrt_pkg::cmd_t                 cmd,
    output itrt_pkg::stat_t                stat,
    input  logic                           cfg_we,
    input  logic [itrt_pkg::RADIX_W-1:0]   cfg_radix,
    input  logic [itrt_pkg::WORD_W-1:0]    value_bits,
    input  logic                           value_is_signed,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [itrt_pkg::CHAR_W-1:0]    char_code,
    output logic                           minus_before,
    output logic                           last_char
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [itrt_pkg::RADIX_W-1:0]  radix_reg;
    logic [itrt_pkg::RADIX_W-1:0]  base_reg;
    logic [itrt_pkg::RADIX_W-1:0]  base_next;
    logic [itrt_pkg::WORD_W-1:0]   div_reg;
    logic [itrt_pkg::WORD_W-1:0]   div_next;
    logic [itrt_pkg::DIGIT_W-1:0]  rem_reg;
    logic [itrt_pkg::DIGIT_W-1:0]  rem_next;
    logic [itrt_pkg::STEP_W-1:0]   step_reg;
    logic [CW-1:0]                 count_reg;
    logic [AW-1:0]                 ptr_reg;
    logic                          neg_reg;
    logic                          first_reg;
    logic                          negative;
    logic                          digit_done;
    logic [itrt_pkg::DIGIT_W-1:0]  rd_digit;
    logic [itrt_pkg::CHAR_W-1:0]   char_next;
    logic                          out_valid_reg;
    logic [itrt_pkg::CHAR_W-1:0]   char_reg;
    logic                          minus_reg;
    logic                          last_reg;

    assign negative   = value_is_signed && value_bits[itrt_pkg::WORD_W-1];
    assign digit_done = cmd.div_step && (step_reg == itrt_pkg::STEP_W'(itrt_pkg::DIV_STEPS - 1));

    // radix register, out-of-range values fall back to decimal at load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itrt_pkg::RADIX_DEFAULT;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_radix;
        end
    end

    always_comb
    begin
        if (radix_reg < itrt_pkg::RADIX_MIN || radix_reg > itrt_pkg::RADIX_MAX)
        begin
            base_next = itrt_pkg::RADIX_DEFAULT;
        end
        else
        begin
            base_next = radix_reg;
        end
    end

    // one divider step: eight dividend bits through a restoring remainder chain
    always_comb
    begin
        logic [itrt_pkg::DIGIT_W:0]    r;
        logic [itrt_pkg::DIV_BITS-1:0] qb;
        r  = {1'b0, rem_reg};
        qb = '0;
        for (int i = 0; i < itrt_pkg::DIV_BITS; i++)
        begin
            r = {r[itrt_pkg::DIGIT_W-1:0], div_reg[itrt_pkg::WORD_W-1-i]};
            if (r >= {1'b0, base_reg})
            begin
                r = r - {1'b0, base_reg};
                qb[itrt_pkg::DIV_BITS-1-i] = 1'b1;
            end
        end
        rem_next = r[itrt_pkg::DIGIT_W-1:0];
        div_next = {div_reg[itrt_pkg::WORD_W-itrt_pkg::DIV_BITS-1:0], qb};
    end

    // dividend/quotient shift register, remainder and operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg  <= negative ? (itrt_pkg::WORD_W'(0) - value_bits) : value_bits;
            rem_reg  <= '0;
            base_reg <= base_next;
            neg_reg  <= negative;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_next;
            rem_reg <= digit_done ? '0 : rem_next;
        end
    end

    // step counter, digit count and emit pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            first_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            step_reg  <= '0;
            count_reg <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + 1'b1;
            if (digit_done)
            begin
                count_reg <= count_reg + 1'b1;
                ptr_reg   <= count_reg[AW-1:0];
            end
        end
        else if (cmd.emit_load)
        begin
            ptr_reg   <= ptr_reg - 1'b1;
            first_reg <= 1'b0;
        end
    end

    // digit store, least significant digit at address zero
    itrt_ram #(
        .WIDTH (itrt_pkg::DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk     (clk),
        .wr_en   (digit_done),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (rem_next),
        .rd_en   (cmd.emit_read),
        .rd_addr (ptr_reg),
        .rd_data (rd_digit)
    );

    // digit value to ascii
    always_comb
    begin
        if (rd_digit < itrt_pkg::DIGIT_TEN)
        begin
            char_next = itrt_pkg::CHAR_ZERO + {1'b0, rd_digit};
        end
        else
        begin
            char_next = itrt_pkg::CHAR_ALPHA_BASE + {1'b0, rd_digit};
        end
    end

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            char_reg  <= char_next;
            minus_reg <= neg_reg && first_reg;
            last_reg  <= (ptr_reg == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign char_code    = char_reg;
    assign minus_before = minus_reg;
    assign last_char    = last_reg;

    // status to controller
    assign stat.step_last   = (step_reg == itrt_pkg::STEP_W'(itrt_pkg::DIV_STEPS - 1));
    assign stat.quot_zero   = (div_next == '0);
    assign stat.digits_full = ((count_reg + 1'b1) == CW'(MAX_DIGITS));
    assign stat.emit_last   = (ptr_reg == '0);
    assign stat.out_free    = !out_valid_reg || out_ready;

endmodule

// File: rtl/integer_to_radix_text_core.sv
// top level of the integer to radix text converter
//
//  channel  direction  signals                      contents
//  s_*      in         s_tvalid/s_tready            value_bits, value_is_signed
//  m_*      out        m_tvalid/m_tready            char_code, minus_before, last_char
//  cfg_*    in         cfg_valid/cfg_ready          radix register
//
// the divider retires eight dividend bits per cycle through a remainder chain, so
// each digit takes a full pass of the dividend, and each character costs a store
// read and an output load on the single read port.
// asynchronous active-low reset; the digit store is not cleared and needs no pass.
// a stalled m_tready holds the output register and pauses emission; s_tready is high
// only between items. cfg_ready is always high.
module integer_to_radix_text_core #(
    parameter int MAX_DIGITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value_bits
    input  logic [0:0]  s_tuser,   // [0] value_is_signed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic [0:0]  m_tuser,   // [0] minus_before
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    itrt_pkg::cmd_t                cmd;
    itrt_pkg::stat_t               stat;
    logic [itrt_pkg::CHAR_W-1:0]   char_code;
    logic                          minus_before;

    // controller
    itrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    itrt_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_valid),
        .cfg_radix       (cfg_data),
        .value_bits      (s_tdata),
        .value_is_signed (s_tuser[0]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .char_code       (char_code),
        .minus_before    (minus_before),
        .last_char       (m_tlast)
    );

    // output packing
    assign m_tdata    = {1'b0, char_code};
    assign m_tuser[0] = minus_before;
    assign cfg_ready  = 1'b1;

endmodule

// File: tb/sv/integer_to_radix_text_core_tb.sv
// self-checking testbench for the integer to radix text converter core
module integer_to_radix_text_core_tb;

    localparam int DIGIT_LIMIT   = 64;
    localparam int PHASE_ITEMS   = 30;
    localparam int RANDOM_PHASES = 8;

    // one number sent on the input stream
    typedef struct packed {
        logic [63:0] bits;
        logic        is_signed;
    } number_t;

    // one character expected on the output stream
    typedef struct packed {
        logic [itrt_pkg::CHAR_W-1:0] code;
        logic                        minus;
        logic                        is_last;
    } text_char_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // block inputs, known from time zero
    logic                         s_tvalid = 1'b0;
    logic [63:0]                  s_tdata = '0;
    logic [0:0]                   s_tuser = '0;
    logic                         m_tready = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic [itrt_pkg::RADIX_W-1:0] cfg_data = '0;

    // block outputs
    logic              s_tready;
    logic              m_tvalid;
    logic [7:0]        m_tdata;
    logic [0:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_ready;

    integer_to_radix_text_core #(
        .MAX_DIGITS (DIGIT_LIMIT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [63:0] value_bits
        .s_tuser   (s_tuser),    // [0] value_is_signed
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [6:0] char_code, [7] zero
        .m_tuser   (m_tuser),    // [0] minus_before
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // testbench state
    number_t                      pending_numbers[$];
    text_char_t                   expected_chars[$];
    logic [itrt_pkg::RADIX_W-1:0] radix_shadow = itrt_pkg::RADIX_DEFAULT;
    int                           send_idle_pct = 0;
    int                           recv_stall_pct = 0;
    int                           mismatch_count = 0;
    number_t                      next_number;
    text_char_t                   want_char;

    // print one mismatch line and count it
    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
        mismatch_count++;
    endtask

    // expected characters of one number under the current radix
    function automatic void predict_text(logic [63:0] bits, logic is_signed);
        logic                         negative;
        logic [63:0]                  mag;
        logic [63:0]                  base;
        logic [itrt_pkg::RADIX_W-1:0] eff;
        logic [itrt_pkg::DIGIT_W-1:0] digit_vals [0:63];
        logic [itrt_pkg::DIGIT_W-1:0] d;
        int                           n;
        text_char_t                   c;
        negative = is_signed & bits[63];
        mag = negative ? (64'd0 - bits) : bits;
        if (radix_shadow < itrt_pkg::RADIX_MIN || radix_shadow > itrt_pkg::RADIX_MAX)
            eff = itrt_pkg::RADIX_DEFAULT;
        else
            eff = radix_shadow;
        base = 64'(eff);
        n = 0;
        if (mag == 64'd0)
        begin
            digit_vals[0] = '0;
            n = 1;
        end
        while (mag != 64'd0 && n < DIGIT_LIMIT)
        begin
            digit_vals[n] = itrt_pkg::DIGIT_W'(mag % base);
            mag = mag / base;
            n++;
        end
        // most significant digit first
        for (int k = 0; k < n; k++)
        begin
            d = digit_vals[n - 1 - k];
            if (d < itrt_pkg::DIGIT_TEN)
                c.code = itrt_pkg::CHAR_ZERO + itrt_pkg::CHAR_W'(d);
            else
                c.code = itrt_pkg::CHAR_ALPHA_BASE + itrt_pkg::CHAR_W'(d);
            c.minus = (k == 0) && negative;
            c.is_last = (k == n - 1);
            expected_chars = {expected_chars, c};
        end
    endfunction

    // random number: mostly random bit lengths, some small negatives, some 32-bit
    function automatic number_t random_number();
        number_t n;
        int      pick;
        int      width;
        pick = $urandom_range(99);
        n.bits = {$urandom, $urandom};
        n.is_signed = 1'($urandom_range(1));
        if (pick < 6)
            n.bits = 64'd0;
        else if (pick < 10)
            n.bits = {64{1'b1}};
        else if (pick < 14)
            n.bits = {1'b1, 63'd0};
        else if (pick < 30)
            n.bits = n.is_signed ? {{32{n.bits[31]}}, n.bits[31:0]} : {32'd0, n.bits[31:0]};
        else
        begin
            width = $urandom_range(64);
            n.bits = (width == 0) ? 64'd0 : n.bits & ({64{1'b1}} >> (64 - width));
            // small-magnitude negatives
            if (n.is_signed && pick < 55)
                n.bits = 64'd0 - n.bits;
        end
        return n;
    endfunction

    // queue one number for the driver
    task automatic push_number(logic [63:0] bits, logic is_signed);
        number_t n;
        n.bits = bits;
        n.is_signed = is_signed;
        pending_numbers = {pending_numbers, n};
    endtask

    // write the radix register while the block is idle
    task automatic write_radix(logic [itrt_pkg::RADIX_W-1:0] r);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        radix_shadow = r;
        @(negedge clk);
    endtask

    // wait until every queued number is sent and every character has come
    task automatic drain();
        while (pending_numbers.size() != 0 || s_tvalid || expected_chars.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // input driver: predict on each transfer, then present the next number
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_text(s_tdata, s_tuser[0]);
            if (!s_tvalid || s_tready)
            begin
                if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_number = pending_numbers.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_number.bits;
                    s_tuser <= next_number.is_signed;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor: random back-pressure and in-order compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected transfer", 64'd0, 64'(m_tdata));
                else
                begin
                    want_char = expected_chars.pop_front();
                    if (m_tdata !== {1'b0, want_char.code})
                        report_mismatch("char_code", 64'(want_char.code), 64'(m_tdata));
                    if (m_tuser[0] !== want_char.minus)
                        report_mismatch("minus_before", 64'(want_char.minus), 64'(m_tuser));
                    if (m_tlast !== want_char.is_last)
                        report_mismatch("last_char", 64'(want_char.is_last), 64'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset radix: zero, extremes, 32-bit extended values
        push_number(64'd0, 1'b0);
        push_number(64'd0, 1'b1);
        push_number(64'd1, 1'b0);
        push_number({64{1'b1}}, 1'b0);
        push_number({64{1'b1}}, 1'b1);
        push_number({1'b1, 63'd0}, 1'b1);
        push_number({1'b1, 63'd0}, 1'b0);
        push_number({1'b0, {63{1'b1}}}, 1'b1);
        push_number(64'hffff_ffff_8000_0000, 1'b1);
        push_number(64'h0000_0000_ffff_ffff, 1'b0);
        drain();

        // largest radix, letter digits
        write_radix(itrt_pkg::RADIX_MAX);
        push_number({64{1'b1}}, 1'b0);
        push_number({1'b1, 63'd0}, 1'b1);
        push_number(64'd35, 1'b0);
        push_number(64'd36, 1'b0);
        push_number(64'd0 - 64'd35, 1'b1);
        drain();

        // smallest radix, full 64-digit runs
        write_radix(itrt_pkg::RADIX_MIN);
        push_number({64{1'b1}}, 1'b0);
        push_number({1'b1, 63'd0}, 1'b1);
        push_number(64'd1, 1'b0);
        drain();

        // out-of-range radix values fall back to decimal
        write_radix(6'd0);
        push_number(64'd0 - 64'd12345, 1'b1);
        push_number(64'd9, 1'b0);
        drain();
        write_radix(6'd1);
        push_number(64'd100, 1'b0);
        drain();
        write_radix(6'd37);
        push_number(64'd100, 1'b0);
        drain();
        write_radix(6'd63);
        push_number(64'd0 - 64'd100, 1'b1);
        drain();

        // random phases, cycling through the idle patterns
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            unique case (p)
                0: write_radix(itrt_pkg::RADIX_MIN);
                1: write_radix(itrt_pkg::RADIX_MAX);
                2: write_radix(6'd16);
                3: write_radix(6'd7);
                default: write_radix(itrt_pkg::RADIX_W'($urandom_range(63)));
            endcase
            unique case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 88;
                end
                default:
                begin
                    send_idle_pct = 8;
                    recv_stall_pct = 8;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // sender holds off mid-phase until the output has fully drained
                if (p == 5 && k == PHASE_ITEMS / 2)
                    drain();
                pending_numbers = {pending_numbers, random_number()};
            end
            drain();
        end

        repeat (20) @(negedge clk);
        if (expected_chars.size() != 0)
            report_mismatch("characters never arrived", 64'(expected_chars.size()), 64'd0);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
